FILE: design/bole_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Shared widths, operation and status codes, and the memory request bundle.
// ----------------------------------------------------------------------------
package bole_pkg;

	localparam int OP_W         = 3;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 8;
	localparam int STATUS_W     = 2;
	localparam int ENTRIES_W    = 9;
	localparam int ADDR_MAX_W   = 8;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_END   = 3'd3,
		OP_DEL_POS   = 3'd4,
		OP_READOUT   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic                      we;
		logic [ADDR_MAX_W-1:0]     waddr;
		logic signed [VALUE_W-1:0] wdata;
		logic                      re;
		logic [ADDR_MAX_W-1:0]     raddr;
	} mem_req_t;

endpackage

FILE: design/bole_if.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine channels
// Request and response channels with a valid/ready handshake per beat.
// ----------------------------------------------------------------------------
interface bole_req_if;
	import bole_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source(output valid, op, value, position, input ready);
	modport sink(input valid, op, value, position, output ready);
endinterface

interface bole_rsp_if;
	import bole_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] element;
	logic                      has_element;
	logic [ENTRIES_W-1:0]      entries;
	logic                      last;

	modport source(output valid, status, element, has_element, entries, last, input ready);
	modport sink(input valid, status, element, has_element, entries, last, output ready);
endinterface

FILE: design/bounded_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete
// and readout requests.
// ----------------------------------------------------------------------------
// Requests arrive on req (op, value, position) and results leave on rsp
// (status, element, has_element, entries, last), each beat moving on valid
// and ready. Every request gives one result beat, except a readout of a
// non-empty list, which gives one beat per entry front to back with last set
// on the final one. The block takes one request at a time; req.ready is high
// only while the sequencer is idle. All entry moves go through one memory
// with one write and one registered read port, so each moved entry is first
// read and then written back. Delete end, refused requests and unused op
// codes go straight to the result; insert end writes the new entry first,
// insert front first shifts every entry up by one, and delete at position p
// first shifts each entry behind p down by one. A readout reads each entry
// before it delivers it. A stalled rsp holds the result register and the
// sequencer waits; a new request may be taken while the final result beat of
// the previous one still waits. Reset empties the list at once; the entry
// memory is not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bole_req_if.sink   req,
	bole_rsp_if.source rsp
);
	import bole_pkg::*;

	mem_req_t                  mem_req;
	logic signed [VALUE_W-1:0] rdata;

	bole_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mem_req(mem_req),
		.rdata  (rdata)
	);

	bole_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.mem_req(mem_req),
		.rdata  (rdata)
	);

endmodule

FILE: design/bole_store.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bole_store #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  bole_pkg::mem_req_t                 mem_req,
	output logic signed [bole_pkg::VALUE_W-1:0] rdata
);
	import bole_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic signed [VALUE_W-1:0] mem_q [CAPACITY];
	logic signed [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rdata_q <= mem_q[mem_req.raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/bole_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine sequencer
// Walks the store one entry at a time for shifts and readouts, and holds
// the response register.
// ----------------------------------------------------------------------------
module bole_ctrl #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bole_req_if.sink                            req,
	bole_rsp_if.source                          rsp,
	output bole_pkg::mem_req_t                  mem_req,
	input  logic signed [bole_pkg::VALUE_W-1:0] rdata
);
	import bole_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_WR,
		S_APPEND,
		S_RM_CHK,
		S_RM_WR,
		S_RD_ISSUE,
		S_RD_EMIT,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             idx_q;
	logic signed [VALUE_W-1:0] value_q;
	status_t                   status_q;

	logic                      rsp_valid_q;
	status_t                   rsp_status_q;
	logic signed [VALUE_W-1:0] rsp_element_q;
	logic                      rsp_has_q;
	logic [ENTRIES_W-1:0]      rsp_entries_q;
	logic                      rsp_last_q;

	logic [AW-1:0] idx_dn;
	logic [AW-1:0] idx_up;
	logic [CW-1:0] idx_next_cnt;
	logic          more_to_move;
	logic          rsp_free;
	logic          rsp_load;
	logic          is_empty;
	logic          is_full;
	logic          pos_bad;

	assign idx_dn       = idx_q - AW'(1);
	assign idx_up       = idx_q + AW'(1);
	assign idx_next_cnt = CW'(idx_q) + CW'(1);
	assign more_to_move = idx_next_cnt < count_q;
	assign rsp_free     = !rsp_valid_q || rsp.ready;
	assign rsp_load     = ((state_q == S_RD_EMIT) || (state_q == S_RESP)) && rsp_free;
	assign is_empty     = count_q == '0;
	assign is_full      = count_q == CW'(CAPACITY);
	assign pos_bad      = (req.position == '0) ||
		({1'b0, req.position} > ENTRIES_W'(count_q));

	assign req.ready = state_q == S_IDLE;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.element     = rsp_element_q;
	assign rsp.has_element = rsp_has_q;
	assign rsp.entries     = rsp_entries_q;
	assign rsp.last        = rsp_last_q;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_INS_CHK: begin
				if (idx_q == '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ADDR_MAX_W'(idx_q);
					mem_req.wdata = value_q;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_MAX_W'(idx_dn);
				end
			end
			S_INS_WR, S_RM_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_MAX_W'(idx_q);
				mem_req.wdata = rdata;
			end
			S_APPEND: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_MAX_W'(idx_q);
				mem_req.wdata = value_q;
			end
			S_RM_CHK: begin
				if (more_to_move) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_MAX_W'(idx_up);
				end
			end
			S_RD_ISSUE: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = ADDR_MAX_W'(idx_q);
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			value_q       <= '0;
			status_q      <= ST_OK;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= ST_OK;
			rsp_element_q <= '0;
			rsp_has_q     <= 1'b0;
			rsp_entries_q <= '0;
			rsp_last_q    <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						value_q <= req.value;
						case (req.op)
							OP_INS_FRONT: begin
								if (is_full) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									idx_q    <= count_q[AW-1:0];
									state_q  <= S_INS_CHK;
								end
							end
							OP_INS_END: begin
								if (is_full) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									idx_q    <= count_q[AW-1:0];
									state_q  <= S_APPEND;
								end
							end
							OP_DEL_FRONT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									idx_q    <= '0;
									state_q  <= S_RM_CHK;
								end
							end
							OP_DEL_END: begin
								state_q <= S_RESP;
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q - CW'(1);
								end
							end
							OP_DEL_POS: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else if (pos_bad) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									idx_q    <= AW'(req.position - POS_W'(1));
									state_q  <= S_RM_CHK;
								end
							end
							OP_READOUT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									idx_q    <= '0;
									state_q  <= S_RD_ISSUE;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_INS_CHK: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_dn;
					state_q <= S_INS_CHK;
				end
				S_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RM_CHK: begin
					if (more_to_move) begin
						state_q <= S_RM_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_up;
					state_q <= S_RM_CHK;
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (rsp_free) begin
						rsp_status_q  <= ST_OK;
						rsp_element_q <= rdata;
						rsp_has_q     <= 1'b1;
						rsp_entries_q <= ENTRIES_W'(count_q);
						rsp_last_q    <= !more_to_move;
						if (more_to_move) begin
							idx_q   <= idx_up;
							state_q <= S_RD_ISSUE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_status_q  <= status_q;
						rsp_element_q <= '0;
						rsp_has_q     <= 1'b0;
						rsp_entries_q <= ENTRIES_W'(count_q);
						rsp_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/bole_chk.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine port checker
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
module bole_chk #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [bole_pkg::STATUS_W-1:0]       rsp_status,
	input logic signed [bole_pkg::VALUE_W-1:0] rsp_element,
	input logic                                rsp_has_element,
	input logic [bole_pkg::ENTRIES_W-1:0]      rsp_entries,
	input logic                                rsp_last
);
	import bole_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while a request was still in progress.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_element) && $stable(rsp_has_element) &&
		$stable(rsp_entries) && $stable(rsp_last))
		else $error("Stalled response beat changed.");

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entries <= ENTRIES_W'(CAPACITY))
		else $error("Reported entry count exceeds capacity.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_entries == ENTRIES_W'(CAPACITY))
		else $error("Full status reported on a list that is not full.");

	a_element_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_has_element |-> rsp_element == '0 && rsp_last)
		else $error("Result without an entry is not a single zero beat.");

endmodule

bind bounded_ordered_list_engine_top bole_chk #(
	.CAPACITY(CAPACITY)
) u_bole_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_element    (rsp.element),
	.rsp_has_element(rsp.has_element),
	.rsp_entries    (rsp.entries),
	.rsp_last       (rsp.last)
);
